/* rtl/core/ple_pkg.sv */
package ple_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_POP    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_INSERT = 3'd3,
    OP_GET    = 3'd4,
    OP_SET    = 3'd5,
    OP_SEARCH = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_DONE
  } seq_state_e;

  localparam int unsigned POS_BITS   = 7;
  localparam int unsigned VALUE_BITS = 32;

  localparam logic signed [POS_BITS-1:0] NOT_FOUND = -7'sd1;

endpackage

/* rtl/core/ple_ram.sv */
module ple_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/positional_list_engine_core.sv */
// Append, set, unused codes and rejected beats pass from idle straight to the done state;
// pop and get pass through the work state for one RAM read; remove, insert and search walk
// the list one entry per cycle in the work state through the single RAM port pair.
// One beat is in flight at a time; the next is taken the cycle after the result reaches the
// output register, and the result waits in the done state while the output stalls. Reset clears the
// length, sequencer and output valid; list entries stay undefined until written.
module positional_list_engine_core #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic [2:0]                                operation_i,
  input  logic [ple_pkg::POS_BITS-1:0]              position_i,
  input  logic [ple_pkg::VALUE_BITS-1:0]            value_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic [ple_pkg::VALUE_BITS-1:0]            read_value_o,
  output logic signed [ple_pkg::POS_BITS-1:0]       found_index_o,
  output logic [ple_pkg::POS_BITS-1:0]              length_now_o,
  output logic [1:0]                                status_o
);

  import ple_pkg::*;

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_BITS) ? CW : POS_BITS;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CW-1:0]        cnt_t;

  seq_state_e state_q, state_d;
  op_e        op_q, op_d;
  word_t      key_q, key_d;
  cnt_t       pos_q, pos_d;
  cnt_t       ptr_q, ptr_d;
  cnt_t       pidx_q, pidx_d;
  logic       pend_q, pend_d;
  cnt_t       count_q, count_d;

  logic [VALUE_BITS-1:0]      res_rd_q, res_rd_d;
  logic signed [POS_BITS-1:0] res_found_q, res_found_d;
  status_e                    res_status_q, res_status_d;

  logic                       out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0]      out_rd_q, out_rd_d;
  logic signed [POS_BITS-1:0] out_found_q, out_found_d;
  logic [POS_BITS-1:0]        out_len_q, out_len_d;
  status_e                    out_status_q, out_status_d;

  logic          we;
  logic [AW-1:0] waddr;
  word_t         wdata;
  logic [AW-1:0] raddr;
  word_t         rd_data;

  logic  in_acc, out_free, is_full, is_empty, pos_ge_cnt, pos_gt_cnt;
  word_t in_word;
  cnt_t  cnt_inc, cnt_dec, ptr_inc, ptr_dec, pidx_inc, pidx_dec;

  ple_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign in_word    = WORD_BITS'(value_i);
  assign is_full    = (count_q == CW'(CAPACITY));
  assign is_empty   = (count_q == '0);
  assign pos_ge_cnt = (CMPW'(position_i) >= CMPW'(count_q));
  assign pos_gt_cnt = (CMPW'(position_i) > CMPW'(count_q));
  assign cnt_inc    = count_q + CW'(1);
  assign cnt_dec    = count_q - CW'(1);
  assign ptr_inc    = ptr_q + CW'(1);
  assign ptr_dec    = ptr_q - CW'(1);
  assign pidx_inc   = pidx_q + CW'(1);
  assign pidx_dec   = pidx_q - CW'(1);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    pos_d        = pos_q;
    ptr_d        = ptr_q;
    pidx_d       = pidx_q;
    pend_d       = pend_q;
    count_d      = count_q;
    res_rd_d     = res_rd_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_rd_d     = out_rd_q;
    out_found_d  = out_found_q;
    out_len_d    = out_len_q;
    out_status_d = out_status_q;
    we           = 1'b0;
    waddr        = '0;
    wdata        = key_q;
    raddr        = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d         = op_e'(operation_i);
          key_d        = in_word;
          pos_d        = CW'(position_i);
          pend_d       = 1'b0;
          res_rd_d     = '0;
          res_found_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_DONE;
          case (op_e'(operation_i))
            OP_APPEND: begin
              if (is_full) begin
                res_status_d = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = count_q[AW-1:0];
                wdata   = in_word;
                count_d = cnt_inc;
              end
            end
            OP_POP: begin
              if (is_empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                raddr   = cnt_dec[AW-1:0];
                count_d = cnt_dec;
                pend_d  = 1'b1;
                state_d = S_WORK;
              end
            end
            OP_REMOVE: begin
              if (is_empty) begin
                res_status_d = ST_EMPTY;
              end else if (pos_ge_cnt) begin
                res_status_d = ST_RANGE;
              end else begin
                ptr_d   = CW'(position_i) + CW'(1);
                state_d = S_WORK;
              end
            end
            OP_INSERT: begin
              if (is_full) begin
                res_status_d = ST_FULL;
              end else if (pos_gt_cnt) begin
                res_status_d = ST_RANGE;
              end else begin
                ptr_d   = count_q;
                state_d = S_WORK;
              end
            end
            OP_GET: begin
              if (is_empty) begin
                res_status_d = ST_EMPTY;
              end else if (pos_ge_cnt) begin
                res_status_d = ST_RANGE;
              end else begin
                raddr   = AW'(position_i);
                pend_d  = 1'b1;
                state_d = S_WORK;
              end
            end
            OP_SET: begin
              if (is_empty) begin
                res_status_d = ST_EMPTY;
              end else if (pos_ge_cnt) begin
                res_status_d = ST_RANGE;
              end else begin
                we    = 1'b1;
                waddr = AW'(position_i);
                wdata = in_word;
              end
            end
            OP_SEARCH: begin
              ptr_d   = '0;
              state_d = S_WORK;
            end
            default: ;
          endcase
        end
      end

      S_WORK: begin
        case (op_q)
          OP_POP, OP_GET: begin
            res_rd_d = VALUE_BITS'(rd_data);
            state_d  = S_DONE;
          end
          OP_REMOVE: begin
            // move the word read last cycle one place down
            if (pend_q) begin
              we    = 1'b1;
              waddr = pidx_dec[AW-1:0];
              wdata = rd_data;
            end
            if (ptr_q < count_q) begin
              raddr  = ptr_q[AW-1:0];
              pidx_d = ptr_q;
              ptr_d  = ptr_inc;
              pend_d = 1'b1;
            end else begin
              pend_d = 1'b0;
              if (!pend_q) begin
                count_d = cnt_dec;
                state_d = S_DONE;
              end
            end
          end
          OP_INSERT: begin
            // walk downwards, moving each word one place up
            if (pend_q) begin
              we    = 1'b1;
              waddr = pidx_inc[AW-1:0];
              wdata = rd_data;
            end
            if (ptr_q > pos_q) begin
              raddr  = ptr_dec[AW-1:0];
              pidx_d = ptr_dec;
              ptr_d  = ptr_dec;
              pend_d = 1'b1;
            end else begin
              pend_d = 1'b0;
              if (!pend_q) begin
                we      = 1'b1;
                waddr   = pos_q[AW-1:0];
                wdata   = key_q;
                count_d = cnt_inc;
                state_d = S_DONE;
              end
            end
          end
          OP_SEARCH: begin
            if (pend_q && (rd_data == key_q)) begin
              res_found_d = POS_BITS'(pidx_q);
              pend_d      = 1'b0;
              state_d     = S_DONE;
            end else if (ptr_q < count_q) begin
              raddr  = ptr_q[AW-1:0];
              pidx_d = ptr_q;
              ptr_d  = ptr_inc;
              pend_d = 1'b1;
            end else if (!pend_q) begin
              res_found_d = NOT_FOUND;
              state_d     = S_DONE;
            end else begin
              pend_d = 1'b0;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        // hold until the output register can take the beat
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_rd_d     = res_rd_q;
          out_found_d  = res_found_q;
          out_len_d    = POS_BITS'(count_q);
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    pos_q        <= pos_d;
    ptr_q        <= ptr_d;
    pidx_q       <= pidx_d;
    res_rd_q     <= res_rd_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    out_rd_q     <= out_rd_d;
    out_found_q  <= out_found_d;
    out_len_q    <= out_len_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_rd_q;
  assign found_index_o = out_found_q;
  assign length_now_o  = out_len_q;
  assign status_o      = out_status_q;

endmodule

/* tb/testbench.sv */
module testbench;
  import ple_pkg::*;

  localparam int          LIST_CAP     = 64;
  localparam logic [2:0]  OP_UNUSED    = 3'd7;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS  = 345;
  localparam int unsigned PRINT_CAP    = 100;

  typedef struct packed {
    logic [2:0]            op;
    logic [POS_BITS-1:0]   pos;
    logic [VALUE_BITS-1:0] value;
  } list_request_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]      read_value;
    logic signed [POS_BITS-1:0] found_index;
    logic [POS_BITS-1:0]        length_now;
    status_e                    status;
  } list_result_t;

  logic                       clk;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  logic [2:0]                 op_drive    = '0;
  logic [POS_BITS-1:0]        pos_drive   = '0;
  logic [VALUE_BITS-1:0]      value_drive = '0;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;
  logic [VALUE_BITS-1:0]      read_value;
  logic signed [POS_BITS-1:0] found_index;
  logic [POS_BITS-1:0]        length_now;
  logic [1:0]                 status;

  list_request_t pending_requests[$];
  list_result_t  owed_results[$];

  // predicted list contents
  logic [VALUE_BITS-1:0] list_words [LIST_CAP];
  int                    model_len = 0;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  logic        hold_go         = 1'b0;
  int unsigned hold_count      = 0;
  logic        in_took         = 1'b0;
  int unsigned idle_run        = 0;
  int unsigned mismatches      = 0;
  int          plan_len        = 0;
  int          plan_target     = 0;

  positional_list_engine_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (op_drive),
    .position_i    (pos_drive),
    .value_i       (value_drive),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .read_value_o  (read_value),
    .found_index_o (found_index),
    .length_now_o  (length_now),
    .status_o      (status)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic list_result_t apply_list_op(list_request_t req);
    list_result_t res;
    int           p;
    res.read_value  = '0;
    res.found_index = '0;
    res.status      = ST_OK;
    p = int'(req.pos);
    case (req.op)
      OP_APPEND: begin
        if (model_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          list_words[model_len] = req.value;
          model_len++;
        end
      end
      OP_POP: begin
        if (model_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          model_len--;
          res.read_value = list_words[model_len];
        end
      end
      OP_REMOVE: begin
        if (model_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p >= model_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = p + 1; i < model_len; i++) list_words[i-1] = list_words[i];
          model_len--;
        end
      end
      OP_INSERT: begin
        if (model_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else if (p > model_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = model_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = req.value;
          model_len++;
        end
      end
      OP_GET: begin
        if (model_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p >= model_len) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = list_words[p];
        end
      end
      OP_SET: begin
        if (model_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p >= model_len) begin
          res.status = ST_RANGE;
        end else begin
          list_words[p] = req.value;
        end
      end
      OP_SEARCH: begin
        res.found_index = NOT_FOUND;
        for (int i = 0; i < model_len; i++) begin
          if (list_words[i] == req.value) begin
            res.found_index = POS_BITS'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    res.length_now = POS_BITS'(model_len);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
  endtask

  task automatic queue_request(logic [2:0] op, int unsigned pos, logic [31:0] value);
    list_request_t req;
    req.op    = op;
    req.pos   = POS_BITS'(pos);
    req.value = value;
    pending_requests.push_back(req);
  endtask

  // Random traffic steered towards a moving target length, so that the list
  // swings between empty, full and everything in between.
  task automatic queue_random_requests(int unsigned n);
    list_request_t req;
    int unsigned   pick;
    int            top;
    repeat (n) begin
      if ($urandom_range(19) == 0) begin
        case ($urandom_range(3))
          0:       plan_target = 0;
          1:       plan_target = LIST_CAP;
          default: plan_target = $urandom_range(LIST_CAP);
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
        req.op = 3'($urandom_range(7));
      end else if (plan_len < plan_target) begin
        req.op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
      end else if (plan_len > plan_target) begin
        req.op = $urandom_range(1) ? OP_POP : OP_REMOVE;
      end else begin
        case ($urandom_range(4))
          0:       req.op = OP_GET;
          1:       req.op = OP_SET;
          2:       req.op = OP_SEARCH;
          3:       req.op = OP_APPEND;
          default: req.op = OP_POP;
        endcase
      end
      if (req.op == OP_INSERT) top = plan_len;
      else top = (plan_len == 0) ? 0 : plan_len - 1;
      if ($urandom_range(4) == 0) req.pos = POS_BITS'($urandom_range(127));
      else req.pos = POS_BITS'($urandom_range(top));
      // small keys give duplicates and search hits
      req.value = $urandom_range(1) ? VALUE_BITS'($urandom_range(7)) : $urandom();
      case (req.op)
        OP_APPEND: if (plan_len < LIST_CAP) plan_len++;
        OP_POP:    if (plan_len > 0) plan_len--;
        OP_REMOVE: if (plan_len > 0 && int'(req.pos) < plan_len) plan_len--;
        OP_INSERT: if (plan_len < LIST_CAP && int'(req.pos) <= plan_len) plan_len++;
        default: ;
      endcase
      pending_requests.push_back(req);
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || owed_results.size() != 0)
      @(posedge clk);
  endtask

  // driver: hold a beat until taken, then offer the next or idle
  always @(negedge clk) begin
    list_request_t req;
    if (rst_n && !(in_valid && !in_took)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        req = pending_requests.pop_front();
        in_valid    <= 1'b1;
        op_drive    <= req.op;
        pos_drive   <= req.pos;
        value_drive <= req.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: a long hold-off once, random stalls otherwise
  always @(negedge clk) begin
    if (hold_go && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk or negedge rst_n) begin
    list_request_t req;
    list_result_t  want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        req.op    = op_drive;
        req.pos   = pos_drive;
        req.value = value_drive;
        owed_results.push_back(apply_list_op(req));
      end
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected beat", '0, '0);
        end else begin
          want = owed_results.pop_front();
          if (read_value !== want.read_value)
            report_mismatch("read_value", read_value, want.read_value);
          if (found_index !== want.found_index)
            report_mismatch("found_index", 32'(found_index), 32'(want.found_index));
          if (length_now !== want.length_now)
            report_mismatch("length_now", 32'(length_now), 32'(want.length_now));
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list, then a handful of words worked through every operation
    queue_request(OP_POP,    0,   32'h0);
    queue_request(OP_REMOVE, 0,   32'h0);
    queue_request(OP_GET,    0,   32'h0);
    queue_request(OP_SET,    0,   32'h1);
    queue_request(OP_SEARCH, 0,   32'h0);
    queue_request(OP_UNUSED, 127, 32'hFFFF_FFFF);
    queue_request(OP_APPEND, 0,   32'h0000_0000);
    queue_request(OP_APPEND, 127, 32'hFFFF_FFFF);
    queue_request(OP_INSERT, 0,   32'h5A5A_5A5A);
    queue_request(OP_INSERT, 3,   32'hA5A5_A5A5);
    queue_request(OP_INSERT, 5,   32'h1111_1111);
    queue_request(OP_GET,    127, 32'h0);
    queue_request(OP_GET,    2,   32'h0);
    queue_request(OP_SET,    1,   32'h1234_5678);
    queue_request(OP_SEARCH, 0,   32'hFFFF_FFFF);
    queue_request(OP_SEARCH, 0,   32'hDEAD_BEEF);
    queue_request(OP_SET,    64,  32'h0);
    queue_request(OP_REMOVE, 4,   32'h0);
    queue_request(OP_REMOVE, 1,   32'h0);
    queue_request(OP_REMOVE, 127, 32'h0);
    queue_request(OP_POP,    0,   32'h0);
    queue_request(OP_GET,    0,   32'h0);
    wait_drained();
    plan_len = model_len;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin sender_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      queue_random_requests(PHASE_ITEMS);
      if (phase == 0) hold_go = 1'b1;
      while (pending_requests.size() != 0) @(posedge clk);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
